>>> design/cpda_pkg.sv
// shared constants, register codes and types of the contact pair distance accumulator
`default_nettype none
package cpda_pkg;
	localparam int MAX_RESIDUES = 4096;
	localparam int FRAC_BITS    = 16;
	localparam int Q_BITS       = 30;
	localparam int RND_SH       = Q_BITS - FRAC_BITS;

	localparam int POS_W   = 12;
	localparam int DIST_W  = 16;
	localparam int SEP_W   = 12;
	localparam int MAXD_W  = 17;
	localparam int MODE_W  = 3;
	localparam int POW_W   = 3;
	localparam int CFG_W   = 17;
	localparam int IDX_W   = 3;
	localparam int OUT_W   = 24;
	localparam int CNT_W   = 24;
	localparam int SUM_W   = 64;
	localparam int WE_W    = DIST_W + 3;
	localparam int MUL_W   = 32;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MIN_SEP     = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_DIST    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SCORE_MODE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SCORE_POWER = 3'd3;
	localparam logic [IDX_W-1:0] REG_WEIGHTS_OFF = 3'd4;

	// similarity modes
	localparam logic [MODE_W-1:0] MODE_RATIO_W1 = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RATIO    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_NDIFF_A  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_NDIFF_B  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NMAX     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_NSUM     = 3'd5;
	localparam logic [MODE_W-1:0] MODE_ABS      = 3'd6;

	localparam logic [SEP_W-1:0]  RST_MIN_SEP  = 12'd3;
	localparam logic [MAXD_W-1:0] RST_MAX_DIST = 17'h1FFFF;
	localparam logic [MODE_W-1:0] RST_MODE     = MODE_NMAX;
	localparam logic [POW_W-1:0]  RST_POWER    = 3'd2;

	localparam logic [SUM_W-1:0] ONE_Q     = 64'd1 << Q_BITS;
	localparam logic [SUM_W-1:0] HALF_Q    = 64'd1 << (Q_BITS - 1);
	localparam logic [SUM_W-1:0] TWO_Q     = 64'd2 << Q_BITS;
	localparam logic [SUM_W-1:0] SMAX      = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SMIN      = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] DIST_NONE = OUT_W'(-(100 <<< FRAC_BITS));

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] num;
		logic [SUM_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quot;
	} div_rsp_t;
endpackage
`default_nettype wire

>>> design/cpda_if.sv
// channel interfaces for column pair items and distance results
`default_nettype none
interface cpda_item_if;
	logic        valid;
	logic        ready;
	logic [11:0] first_pos_a;
	logic [11:0] first_pos_b;
	logic [11:0] second_pos_a;
	logic [11:0] second_pos_b;
	logic [15:0] first_dist;
	logic [15:0] second_dist;
	logic        last_pair;
	modport source(output valid, first_pos_a, first_pos_b, second_pos_a, second_pos_b,
		first_dist, second_dist, last_pair, input ready);
	modport sink(input valid, first_pos_a, first_pos_b, second_pos_a, second_pos_b,
		first_dist, second_dist, last_pair, output ready);
endinterface

interface cpda_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pair_distance;
	logic               no_usable_pairs;
	logic        [23:0] pairs_used;
	modport source(output valid, pair_distance, no_usable_pairs, pairs_used, input ready);
	modport sink(input valid, pair_distance, no_usable_pairs, pairs_used, output ready);
endinterface
`default_nettype wire

>>> design/cpda_div.sv
// radix-2 restoring divider, one quotient bit per cycle, result rounded half up
`default_nettype none
module cpda_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cpda_pkg::div_req_t req,
	output cpda_pkg::div_rsp_t      rsp
);
	import cpda_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]  num_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [SUM_W-1:0]  quot_q;
	logic [SUM_W:0]    trial;
	logic              fits;
	logic              rnd_up;

	assign trial  = {rem_q, num_q[SUM_W-1]};
	assign fits   = trial >= {1'b0, den_q};
	assign rnd_up = {rem_q, 1'b0} >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SUM_W-2:0], fits};
			rem_q <= fits ? SUM_W'(trial - {1'b0, den_q}) : trial[SUM_W-1:0];
		end
		if (fin_q) quot_q <= num_q + SUM_W'(rnd_up);
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule
`default_nettype wire

>>> design/cpda_mul.sv
// registered 32 x 32 multiplier shared by the power and weighting steps
`default_nettype none
module cpda_mul (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [cpda_pkg::MUL_W-1:0] a,
	input  wire logic [cpda_pkg::MUL_W-1:0] b,
	output logic [2*cpda_pkg::MUL_W-1:0]    prod
);
	import cpda_pkg::*;

	logic [2*MUL_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

>>> design/contact_pair_distance_accumulator.sv
// top level: filters column pairs, accumulates similarity terms, reports pair distance
// a filtered item goes straight to the check, a contributing item runs the divider and one
//   to four shared multiplies, an absolute-difference item skips the divider, and a last
//   item with nonzero weight and non-negative score adds the final division before output
// throughput: one item at a time, input ready only while the sequencer idles
// reset: async active low, config registers return to defaults, sums and count clear
`default_nettype none
module contact_pair_distance_accumulator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [cpda_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [cpda_pkg::CFG_W-1:0] cfg_data,
	cpda_item_if.sink                       items,
	cpda_result_if.source                   results
);
	import cpda_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIV   = 4'd1;
	localparam logic [3:0] S_POW   = 4'd2;
	localparam logic [3:0] S_POWW  = 4'd3;
	localparam logic [3:0] S_TERM  = 4'd4;
	localparam logic [3:0] S_TERMW = 4'd5;
	localparam logic [3:0] S_ACC   = 4'd6;
	localparam logic [3:0] S_CHK   = 4'd7;
	localparam logic [3:0] S_FDIV  = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	// configuration registers
	logic [SEP_W-1:0]  min_sep_q;
	logic [MAXD_W-1:0] max_dist_q;
	logic [MODE_W-1:0] mode_q;
	logic [POW_W-1:0]  power_q;
	logic              wts_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sep_q  <= RST_MIN_SEP;
			max_dist_q <= RST_MAX_DIST;
			mode_q     <= RST_MODE;
			power_q    <= RST_POWER;
			wts_off_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_SEP:     min_sep_q  <= cfg_data[SEP_W-1:0];
				REG_MAX_DIST:    max_dist_q <= cfg_data[MAXD_W-1:0];
				REG_SCORE_MODE:  mode_q     <= cfg_data[MODE_W-1:0];
				REG_SCORE_POWER: power_q    <= cfg_data[POW_W-1:0];
				REG_WEIGHTS_OFF: wts_off_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// filter and operand prep on the incoming transaction
	logic [3:0]        state_q;
	logic              last_q;
	logic              accept;
	logic [POS_W-1:0]  sep1;
	logic [POS_W-1:0]  sep2;
	logic              gap;
	logic              pass;
	logic [DIST_W-1:0] d1;
	logic [DIST_W-1:0] d2;
	logic [DIST_W-1:0] hi;
	logic [DIST_W-1:0] lo;
	logic [DIST_W-1:0] diff;
	logic [DIST_W:0]   dsum;
	logic [WE_W-1:0]   we2;
	logic [POW_W-1:0]  p_eff;
	logic              use_div;

	function automatic logic bad_pos(input logic [POS_W-1:0] p);
		return (p == '0) || (32'(p) >= MAX_RESIDUES);
	endfunction

	assign d1     = items.first_dist;
	assign d2     = items.second_dist;
	assign hi     = (d1 > d2) ? d1 : d2;
	assign lo     = (d1 > d2) ? d2 : d1;
	assign diff   = hi - lo;
	assign dsum   = {1'b0, d1} + {1'b0, d2};
	assign sep1   = (items.first_pos_a > items.first_pos_b) ?
		items.first_pos_a - items.first_pos_b : items.first_pos_b - items.first_pos_a;
	assign sep2   = (items.second_pos_a > items.second_pos_b) ?
		items.second_pos_a - items.second_pos_b : items.second_pos_b - items.second_pos_a;
	assign gap    = bad_pos(items.first_pos_a) || bad_pos(items.first_pos_b) ||
		bad_pos(items.second_pos_a) || bad_pos(items.second_pos_b);
	assign pass   = !gap && (sep1 >= min_sep_q) && (sep2 >= min_sep_q) &&
		(d1 != '0) && (d2 != '0) && ({1'b0, d1} <= max_dist_q) && ({1'b0, d2} <= max_dist_q);
	assign accept = items.valid && items.ready;
	assign items.ready = (state_q == S_IDLE);
	assign use_div = (mode_q <= MODE_NSUM);

	// doubled term weight
	always_comb begin
		case (mode_q)
			MODE_RATIO_W1:              we2 = WE_W'({d1, 1'b0});
			MODE_RATIO, MODE_NDIFF_A,
			MODE_NDIFF_B:               we2 = WE_W'(dsum);
			MODE_NMAX:                  we2 = WE_W'({hi, 1'b0});
			MODE_NSUM:                  we2 = WE_W'({dsum, 1'b0});
			MODE_ABS:                   we2 = WE_W'(2);
			default:                    we2 = '0;
		endcase
		if (wts_off_q) we2 = WE_W'(2);
	end

	assign p_eff = (power_q == '0) ? POW_W'(1) : ((power_q > POW_W'(4)) ? POW_W'(4) : power_q);

	// shared divider, per-item ratio and the final score/weight quotient
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [SUM_W-1:0] sum_num;
	logic [SUM_W-1:0] sum_den;

	always_comb begin
		sum_num = '0;
		sum_den = 64'(hi);
		case (mode_q)
			MODE_RATIO_W1, MODE_RATIO: begin
				sum_num = 64'(lo) << Q_BITS;
				sum_den = 64'(hi);
			end
			MODE_NDIFF_A, MODE_NDIFF_B: begin
				sum_num = 64'({diff, 1'b0}) << Q_BITS;
				sum_den = 64'(dsum);
			end
			MODE_NMAX: begin
				sum_num = 64'(diff) << Q_BITS;
				sum_den = 64'(hi);
			end
			MODE_NSUM: begin
				sum_num = 64'(diff) << Q_BITS;
				sum_den = 64'(dsum);
			end
			default: ;
		endcase
	end

	logic signed [SUM_W-1:0] score_q;
	logic        [SUM_W-1:0] weight_q;
	logic        [CNT_W-1:0] used_q;

	always_comb begin
		div_req = '0;
		if (accept && pass && use_div) begin
			div_req.start = 1'b1;
			div_req.num   = sum_num;
			div_req.den   = sum_den;
		end else if (state_q == S_CHK && last_q && weight_q != '0 && !score_q[SUM_W-1]) begin
			div_req.start = 1'b1;
			div_req.num   = score_q;
			div_req.den   = weight_q;
		end
	end

	cpda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// per-item working registers
	logic [DIST_W-1:0] diff_q;
	logic [WE_W-1:0]   we2_q;
	logic [POW_W-1:0]  p_q;
	logic [POW_W-1:0]  k_q;
	logic [Q_BITS:0]   mag_q;
	logic              neg_q;
	logic [MUL_W-1:0]  acc_q;
	logic              sat_q;
	logic [SUM_W-1:0]  term_q;
	logic [MUL_W-1:0]  fq_q;

	// magnitude and sign of the similarity term from the rounded quotient
	logic [SUM_W-1:0] dq;
	logic [Q_BITS:0]  mag_new;
	logic             neg_new;

	assign dq = div_rsp.quot;

	always_comb begin
		neg_new = 1'b0;
		case (mode_q)
			MODE_RATIO_W1, MODE_RATIO: mag_new = dq[Q_BITS:0];
			MODE_NDIFF_A, MODE_NDIFF_B: begin
				if (dq > ONE_Q) begin
					neg_new = 1'b1;
					mag_new = (Q_BITS+1)'(dq - ONE_Q);
				end else begin
					mag_new = (Q_BITS+1)'(ONE_Q - dq);
				end
			end
			default: mag_new = (Q_BITS+1)'(ONE_Q - dq);
		endcase
	end

	// shared multiplier: power steps, then the weight product
	logic               mul_en;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] prod;
	logic               is_abs;

	assign is_abs = (mode_q == MODE_ABS);
	assign mul_en = (state_q == S_POW && k_q < p_q) || (state_q == S_TERM);
	assign mul_a  = acc_q;
	assign mul_b  = (state_q == S_TERM) ? MUL_W'(we2_q) :
		(is_abs ? MUL_W'(diff_q) : MUL_W'(mag_q));

	cpda_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	logic [2*MUL_W-1:0] prod_rnd;
	assign prod_rnd = (prod + HALF_Q) >> Q_BITS;

	// saturating accumulation
	logic [SUM_W-1:0] score_add;
	logic             score_ovf;
	logic [SUM_W:0]   weight_add;

	assign score_add  = score_q + term_q;
	assign score_ovf  = (score_q[SUM_W-1] == term_q[SUM_W-1]) &&
		(score_add[SUM_W-1] != score_q[SUM_W-1]);
	assign weight_add = {1'b0, weight_q} + (SUM_W+1)'(we2_q);

	// final distance 100*(1-q), rounded half away from zero to the output scale
	logic signed [Q_BITS+3:0]  one_minus;
	logic signed [Q_BITS+10:0] v100;
	logic        [Q_BITS+10:0] vmag;
	logic        [Q_BITS+10:0] vrnd;
	logic        [OUT_W-1:0]   dist_fin;

	assign one_minus = $signed((Q_BITS+4)'(ONE_Q)) - $signed({2'b00, fq_q});
	assign v100 = ((Q_BITS+11)'(one_minus) <<< 6) + ((Q_BITS+11)'(one_minus) <<< 5) +
		((Q_BITS+11)'(one_minus) <<< 2);
	assign vmag = v100[Q_BITS+10] ? (Q_BITS+11)'(-v100) : v100;
	assign vrnd = (vmag + ((Q_BITS+11)'(1) << (RND_SH - 1))) >> RND_SH;
	assign dist_fin = v100[Q_BITS+10] ? OUT_W'(-vrnd) : OUT_W'(vrnd);

	// result staging and output register
	logic [OUT_W-1:0] res_dist_q;
	logic             res_none_q;
	logic             ovalid_q;
	logic [OUT_W-1:0] odist_q;
	logic             onone_q;
	logic [CNT_W-1:0] oused_q;
	logic             out_free;
	logic             load_out;

	assign out_free = !ovalid_q || results.ready;
	assign load_out = (state_q == S_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			score_q  <= '0;
			weight_q <= '0;
			used_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) ovalid_q <= 1'b1;
			else if (results.ready) ovalid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!pass) state_q <= S_CHK;
						else if (use_div) state_q <= S_DIV;
						else if (is_abs) state_q <= S_POW;
						else state_q <= S_ACC;
					end
				end
				S_DIV:   if (div_rsp.done) state_q <= S_POW;
				S_POW: begin
					if (k_q < p_q) state_q <= S_POWW;
					else if (is_abs) state_q <= S_ACC;
					else state_q <= S_TERM;
				end
				S_POWW:  state_q <= S_POW;
				S_TERM:  state_q <= S_TERMW;
				S_TERMW: state_q <= S_ACC;
				S_ACC: begin
					score_q  <= score_ovf ? (score_q[SUM_W-1] ? SMIN : SMAX) : score_add;
					weight_q <= weight_add[SUM_W] ? '1 : weight_add[SUM_W-1:0];
					if (used_q != '1) used_q <= used_q + 1'b1;
					state_q  <= S_CHK;
				end
				S_CHK: begin
					if (!last_q) state_q <= S_IDLE;
					else if (weight_q == '0) state_q <= S_OUT;
					else if (score_q[SUM_W-1]) state_q <= S_FIN;
					else state_q <= S_FDIV;
				end
				S_FDIV:  if (div_rsp.done) state_q <= S_FIN;
				S_FIN:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						score_q  <= '0;
						weight_q <= '0;
						used_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					last_q <= items.last_pair;
					diff_q <= diff;
					we2_q  <= we2;
					p_q    <= p_eff;
					k_q    <= POW_W'(1);
					acc_q  <= MUL_W'(diff);
					sat_q  <= 1'b0;
					neg_q  <= 1'b0;
					term_q <= '0;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					mag_q <= mag_new;
					neg_q <= neg_new;
					acc_q <= MUL_W'(mag_new);
				end
			end
			S_POW: begin
				// abs mode: diff^p, saturating once past 32 bits
				if (k_q >= p_q && is_abs)
					term_q <= sat_q ? SMAX : {1'b0, acc_q, {(SUM_W-MUL_W-1){1'b0}}};
			end
			S_POWW: begin
				k_q <= k_q + 1'b1;
				if (is_abs) begin
					if (prod[2*MUL_W-1:MUL_W] != '0) begin
						sat_q <= 1'b1;
						acc_q <= '1;
					end else begin
						acc_q <= prod[MUL_W-1:0];
					end
				end else begin
					acc_q <= prod_rnd[MUL_W-1:0];
				end
			end
			S_TERMW: term_q <= (neg_q && p_q[0]) ? SUM_W'(-prod) : prod;
			S_CHK: begin
				res_none_q <= (weight_q == '0);
				res_dist_q <= DIST_NONE;
				fq_q       <= '0;
			end
			S_FDIV: begin
				if (div_rsp.done) fq_q <= (div_rsp.quot > TWO_Q) ? MUL_W'(TWO_Q) : MUL_W'(div_rsp.quot);
			end
			S_FIN: res_dist_q <= dist_fin;
			default: ;
		endcase

		if (load_out) begin
			odist_q <= res_dist_q;
			onone_q <= res_none_q;
			oused_q <= used_q;
		end
	end

	assign results.valid           = ovalid_q;
	assign results.pair_distance   = $signed(odist_q);
	assign results.no_usable_pairs = onone_q;
	assign results.pairs_used      = oused_q;
endmodule
`default_nettype wire
